@@ rtl/bubble_sort_descending_defines.svh @@
// Assertion macros for the descending bubble sort RTL.
// Included by bsd_back, which carries concurrent checks; needs no package.
`ifndef BUBBLE_SORT_DESCENDING_DEFINES_SVH
`define BUBBLE_SORT_DESCENDING_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define BSD_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("bubble sort check failed");

// Check that cons holds in the cycle after ante.
`define BSD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("bubble sort check failed");

`endif

@@ rtl/bsd_pkg.sv @@
// Shared types and constants of the descending bubble sort.
// No dependencies; used by the interfaces and every module.
package bsd_pkg;

  localparam int DataW      = 32;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // One classified item as it travels from the front to the sorter
  typedef struct packed {
    logic signed [DataW-1:0] value;
    logic                    last_item;
    logic                    keep;
  } bsd_entry_t;

  // Sorter sequence
  typedef enum logic [2:0] {
    S_LOAD,
    S_PASS_FIRST,
    S_PASS_RUN,
    S_PASS_END,
    S_EMIT
  } bsd_state_e;

endpackage

@@ rtl/bsd_if.sv @@
// Valid/ready channel interfaces for the input values and the sorted results.
// Depends on bsd_pkg for the data width.
interface bsd_in_if import bsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] value;
  logic                    last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bsd_out_if import bsd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] sorted_value;
  logic                    last_result;
  logic                    overflow;

  modport source (output valid, output sorted_value, output last_result,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_result,
                  input overflow, output ready);
endinterface

@@ rtl/bsd_front.sv @@
// Input front end: accepts values and marks each as kept or dropped.
// Depends on bsd_pkg and bsd_in_if.
module bsd_front import bsd_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bsd_in_if.sink       in_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output bsd_entry_t   push_data_o
);

  localparam int CntW = $clog2(MAX_ITEMS + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            keep;
  logic            fire;

  // Pass the channel straight into the queue
  assign in_i.ready   = push_ready_i;
  assign push_valid_o = in_i.valid;
  assign fire         = in_i.valid && push_ready_i;

  // Keep a value only while the set still fits in the store
  assign keep = (cnt_q < CntW'(MAX_ITEMS));

  assign push_data_o.value     = in_i.value;
  assign push_data_o.last_item = in_i.last_item;
  assign push_data_o.keep      = keep;

  // Count kept values of the current set; restart on the closing value
  always_comb begin
    cnt_d = cnt_q;
    if (fire) begin
      if (in_i.last_item) begin
        cnt_d = '0;
      end else if (keep) begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/bsd_fifo.sv @@
// Short queue between the front end and the sorter.
// Depends on bsd_pkg for the entry type and depth.
module bsd_fifo import bsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_valid_i,
  output logic       push_ready_o,
  input  bsd_entry_t push_data_i,
  output logic       pop_valid_o,
  input  logic       pop_ready_i,
  output bsd_entry_t pop_data_o
);

  bsd_entry_t       slot_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             push_fire, pop_fire;

  assign push_ready_o = (count_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = slot_q[rd_ptr_q];
  assign push_fire    = push_valid_i && push_ready_o;
  assign pop_fire     = pop_valid_o && pop_ready_i;

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_fire) begin
      slot_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop_fire) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push_fire && !pop_fire) begin
        count_q <= count_q + QCntW'(1);
      end else if (pop_fire && !push_fire) begin
        count_q <= count_q - QCntW'(1);
      end
    end
  end

endmodule

@@ rtl/bsd_back.sv @@
// Sorter back end: loads the set into a memory, bubble-sorts it with one
// compare per cycle within a pass and streams it out. Depends on bsd_pkg,
// bsd_out_if and the assertion macros.
`include "bubble_sort_descending_defines.svh"

module bsd_back import bsd_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       pop_valid_i,
  output logic       pop_ready_o,
  input  bsd_entry_t pop_data_i,
  bsd_out_if.source  out_o
);

  localparam int AddrW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CntW  = $clog2(MAX_ITEMS + 1);

  bsd_state_e              state_q, state_d;
  logic [CntW-1:0]         held_q, held_d, held_after, held_last;
  logic                    dropped_q, dropped_d;
  logic [AddrW-1:0]        bound_q, bound_d;
  logic [AddrW-1:0]        idx_q, idx_d, idx_next;
  logic                    clean_q, clean_d;
  logic signed [DataW-1:0] carry_q, carry_d;

  logic signed [DataW-1:0] store_q [MAX_ITEMS];
  logic signed [DataW-1:0] rd_data_q;
  logic                    rd_en, we;
  logic [AddrW-1:0]        rd_addr, wr_addr;
  logic signed [DataW-1:0] wr_data;

  logic                    out_valid_q, out_valid_d;
  logic signed [DataW-1:0] out_value_q;
  logic                    out_last_q, out_ovf_q;
  logic                    out_free, out_load, emit_last;

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.last_result  = out_last_q;
  assign out_o.overflow     = out_ovf_q;

  assign out_free   = !out_valid_q || out_o.ready;
  assign held_last  = held_q - CntW'(1);
  assign emit_last  = (CntW'(idx_q) == held_last);
  assign idx_next   = idx_q + AddrW'(1);
  assign held_after = (pop_data_i.keep) ? held_q + CntW'(1) : held_q;

  // Sequence load, passes and emission
  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    dropped_d   = dropped_q;
    bound_d     = bound_q;
    idx_d       = idx_q;
    clean_d     = clean_q;
    carry_d     = carry_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    we          = 1'b0;
    wr_addr     = '0;
    wr_data     = carry_q;
    pop_ready_o = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !out_o.ready;

    unique case (state_q)
      S_LOAD: begin
        pop_ready_o = 1'b1;
        if (pop_valid_i) begin
          if (pop_data_i.keep) begin
            we      = 1'b1;
            wr_addr = AddrW'(held_q);
            wr_data = pop_data_i.value;
            held_d  = held_after;
          end else begin
            dropped_d = 1'b1;
          end
          // Closing value: fetch the head entry and start sorting or emitting
          if (pop_data_i.last_item) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            if (held_after >= CntW'(2)) begin
              bound_d = AddrW'(held_after - CntW'(1));
              state_d = S_PASS_FIRST;
            end else begin
              state_d = S_EMIT;
            end
          end
        end
      end

      S_PASS_FIRST: begin
        carry_d = rd_data_q;
        clean_d = 1'b1;
        idx_d   = '0;
        rd_en   = 1'b1;
        rd_addr = AddrW'(1);
        state_d = S_PASS_RUN;
      end

      S_PASS_RUN: begin
        // Carry the smaller value forward; settle the larger into place
        we      = 1'b1;
        wr_addr = idx_q;
        if (carry_q < rd_data_q) begin
          wr_data = rd_data_q;
          clean_d = 1'b0;
        end else begin
          wr_data = carry_q;
          carry_d = rd_data_q;
        end
        if (idx_next == bound_q) begin
          state_d = S_PASS_END;
        end else begin
          rd_en   = 1'b1;
          rd_addr = idx_q + AddrW'(2);
          idx_d   = idx_next;
        end
      end

      S_PASS_END: begin
        // Park the carried value at the pass end and restart from the head
        we      = 1'b1;
        wr_addr = bound_q;
        wr_data = carry_q;
        rd_en   = 1'b1;
        rd_addr = '0;
        idx_d   = '0;
        if (clean_q || bound_q == AddrW'(1)) begin
          state_d = S_EMIT;
        end else begin
          bound_d = bound_q - AddrW'(1);
          state_d = S_PASS_FIRST;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          if (emit_last) begin
            held_d    = '0;
            dropped_d = 1'b0;
            state_d   = S_LOAD;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_next;
            idx_d   = idx_next;
          end
        end
      end

      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  // Value store with registered read; forward a same-address write
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= (we && wr_addr == rd_addr) ? wr_data : store_q[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    carry_q <= carry_d;
    if (out_load) begin
      out_value_q <= rd_data_q;
      out_last_q  <= emit_last;
      out_ovf_q   <= dropped_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      held_q      <= '0;
      dropped_q   <= 1'b0;
      bound_q     <= '0;
      idx_q       <= '0;
      clean_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      dropped_q   <= dropped_d;
      bound_q     <= bound_d;
      idx_q       <= idx_d;
      clean_q     <= clean_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Sort writes stay inside the current set
  `BSD_ASSERT_IMPLY(a_write_in_set, clk_i, rst_ni, we && state_q != S_LOAD, CntW'(wr_addr) < held_q)
  // The pair under compare lies inside the pass
  `BSD_ASSERT_IMPLY(a_pair_in_pass, clk_i, rst_ni, state_q == S_PASS_RUN, idx_q < bound_q)
  // Emitting the final result empties the set
  `BSD_ASSERT_NEXT(a_last_clears, clk_i, rst_ni, out_load && emit_last, state_q == S_LOAD && held_q == '0 && !dropped_q)
  // The held count never passes the store depth
  `BSD_ASSERT_IMPLY(a_held_cap, clk_i, rst_ni, state_q != S_LOAD, held_q <= CntW'(MAX_ITEMS) && held_q != '0)

endmodule

@@ rtl/bubble_sort_descending.sv @@
// Channel    | Dir | Fields                                   | Moves
// in_i       | in  | value[31:0] signed, last_item            | one value per transfer
// out_o      | out | sorted_value[31:0] signed, last_result,  | one result per transfer
//            |     | overflow                                 |
// Loading: values pass through a four-entry queue and are taken back to back while the sorter loads.
// Sort: at most N-1 passes for a set of N values, on the one-read one-write value store.
// Output: one result per cycle while out_o is ready; the output register
// lets the next set load while the last result waits.
// Reset: asynchronous, active low; the store needs no clearing.
//
// Top level of the descending bubble sort. Depends on bsd_pkg, the channel
// interfaces, bsd_front, bsd_fifo and bsd_back.
module bubble_sort_descending import bsd_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  bsd_in_if.sink    in_i,
  bsd_out_if.source out_o
);

  logic       push_valid, push_ready;
  bsd_entry_t push_data;
  logic       pop_valid, pop_ready;
  bsd_entry_t pop_data;

  // Classify incoming values
  bsd_front #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  // Decouple front and sorter
  bsd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  // Store, sort and emit
  bsd_back #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_o       (out_o)
  );

endmodule

@@ tb/bubble_sort_descending_checker.sv @@
// Watches both channels of the descending bubble sort and predicts each set's output.
// Depends on bsd_pkg and the bsd_in_if / bsd_out_if channel interfaces.
`timescale 1ns / 1ps

module bubble_sort_descending_checker import bsd_pkg::*; #(
  parameter int MAX_ITEMS = 64
) (
  input  logic clk_i,
  input  logic rst_ni,
  bsd_in_if    in_mon,
  bsd_out_if   out_mon,
  output int   mismatch_count_o,
  output int   pending_count_o
);

  typedef struct {
    logic signed [DataW-1:0] sorted_value;
    logic                    last_result;
    logic                    overflow;
  } sorted_result_t;

  // Values of the set now being collected
  logic signed [DataW-1:0] set_values [MAX_ITEMS];
  int                      set_size;
  bit                      set_dropped;

  // Results of closed sets not yet seen on the output
  sorted_result_t          pending_sorted [$];

  // Sort the collected set in place, largest first, and queue its results; equal values keep their order.
  task automatic close_and_sort_set();
    logic signed [DataW-1:0] swap_value;
    int                      bound;
    bit                      clean;
    sorted_result_t          res;
    clean = 1'b0;
    for (bound = set_size - 1; bound > 0 && !clean; bound--) begin
      clean = 1'b1;
      for (int k = 0; k < bound; k++) begin
        if (set_values[k] < set_values[k+1]) begin
          swap_value      = set_values[k];
          set_values[k]   = set_values[k+1];
          set_values[k+1] = swap_value;
          clean           = 1'b0;
        end
      end
    end
    for (int k = 0; k < set_size; k++) begin
      res.sorted_value = set_values[k];
      res.last_result  = (k == set_size - 1);
      res.overflow     = set_dropped;
      pending_sorted.push_back(res);
    end
    set_size    = 0;
    set_dropped = 1'b0;
  endtask

  // Compare one output transfer with the oldest pending result.
  task automatic compare_result();
    sorted_result_t exp_res;
    if (pending_sorted.size() == 0) begin
      $error("unexpected result: sorted_value %0d, last_result %0b, overflow %0b",
             out_mon.sorted_value, out_mon.last_result, out_mon.overflow);
      mismatch_count_o++;
    end else begin
      exp_res = pending_sorted.pop_front();
      if (out_mon.sorted_value !== exp_res.sorted_value) begin
        $error("sorted_value mismatch: expected %0d, actual %0d",
               exp_res.sorted_value, out_mon.sorted_value);
        mismatch_count_o++;
      end
      if (out_mon.last_result !== exp_res.last_result) begin
        $error("last_result mismatch: expected %0b, actual %0b",
               exp_res.last_result, out_mon.last_result);
        mismatch_count_o++;
      end
      if (out_mon.overflow !== exp_res.overflow) begin
        $error("overflow mismatch: expected %0b, actual %0b",
               exp_res.overflow, out_mon.overflow);
        mismatch_count_o++;
      end
    end
  endtask

  // Sample both channels at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size    = 0;
      set_dropped = 1'b0;
      pending_sorted.delete();
      mismatch_count_o = 0;
      pending_count_o  = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        compare_result();
      end
      if (in_mon.valid && in_mon.ready) begin
        // Store the value, or drop it once the set is full
        if (set_size < MAX_ITEMS) begin
          set_values[set_size] = in_mon.value;
          set_size++;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_mon.last_item) begin
          close_and_sort_set();
        end
      end
      pending_count_o = pending_sorted.size();
    end
  end

endmodule

@@ tb/bubble_sort_descending_tb.sv @@
// Top of the descending bubble sort testbench: clock, reset, stimulus and verdict.
// Depends on bsd_pkg, the channel interfaces, the RTL and the checker module.
`timescale 1ns / 1ps

module bubble_sort_descending_tb import bsd_pkg::*; ();

  localparam int MaxItems       = 64;
  localparam int RandomItems    = 356;
  localparam int QuietFrom      = 300;
  localparam int LongHoldCycles = 600;

  localparam logic signed [DataW-1:0] ValMax = {1'b0, {(DataW-1){1'b1}}};
  localparam logic signed [DataW-1:0] ValMin = {1'b1, {(DataW-1){1'b0}}};

  logic clk_i = 1'b0;
  logic rst_ni;

  bsd_in_if  in_if ();
  bsd_out_if out_if ();

  int mismatch_count;
  int pending_count;

  // Set by the stimulus and read by the receiver: hold_go, quiet; hold_done is the receiver's, gap_pct the stimulus's
  bit hold_go;
  bit hold_done;
  bit quiet;
  int gap_pct;

  bubble_sort_descending #(
    .MAX_ITEMS(MaxItems)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  bubble_sort_descending_checker #(
    .MAX_ITEMS(MaxItems)
  ) checker_u (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .mismatch_count_o(mismatch_count),
    .pending_count_o (pending_count)
  );

  always #1 clk_i = ~clk_i;

  // Bias values toward extremes and near-duplicates
  function automatic logic signed [DataW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return ValMax;
      1:       return ValMin;
      2:       return $urandom_range(0, 1) ? '0 : '1;
      3, 4:    return $signed($urandom_range(0, 8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  // Mostly small sets; a full set and an overflowing one are forced
  function automatic int pick_set_size(input int set_idx);
    if (set_idx == 4) return MaxItems;
    if (set_idx == 12) return MaxItems + 3;
    case ($urandom_range(0, 19))
      0:          return $urandom_range(MaxItems - 2, MaxItems + 4);
      1, 2, 3:    return $urandom_range(11, 24);
      default:    return $urandom_range(1, 10);
    endcase
  endfunction

  // Offer one set, one transfer per value, with random gaps between values
  task automatic send_set(input logic signed [DataW-1:0] vals[$]);
    for (int k = 0; k < vals.size(); k++) begin
      if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      in_if.valid     <= 1'b1;
      in_if.value     <= vals[k];
      in_if.last_item <= (k == vals.size() - 1);
      do @(posedge clk_i); while (!in_if.ready);
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic signed [DataW-1:0] set_vals[$];
    int random_items;
    int set_idx;
    int set_len;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.value     <= '0;
    in_if.last_item <= 1'b0;
    hold_go   = 1'b0;
    quiet     = 1'b0;
    gap_pct   = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single-value sets, extremes with duplicates, reversed and sorted input, an all-equal set
    send_set('{ValMax});
    send_set('{ValMin});
    gap_pct = 30;
    send_set('{ValMin, ValMax, 0, -1, 1, ValMax, ValMin});
    send_set('{1, 2, 3, 4, 5, 6});
    gap_pct = 0;
    send_set('{40, 30, 20, 10, -10});
    send_set('{7, 7, 7});

    // Random sets; the receiver stalls for a long stretch at the start
    hold_go      = 1'b1;
    random_items = 0;
    set_idx      = 0;
    while (random_items < RandomItems) begin
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 20;
        default: gap_pct = 50;
      endcase
      set_len = pick_set_size(set_idx);
      set_vals.delete();
      repeat (set_len) set_vals.push_back(pick_value());
      send_set(set_vals);
      random_items += set_len;
      set_idx++;
      if (random_items >= QuietFrom) quiet = 1'b1;
    end
    in_if.valid <= 1'b0;

    // Drain the outstanding results
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Output side: random stall bursts plus one long hold-off
  initial begin : receiver
    int stall_pct;
    out_if.ready <= 1'b0;
    hold_done = 1'b0;
    stall_pct = 0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LongHoldCycles) @(posedge clk_i);
      end else if (!quiet && $urandom_range(1, 100) <= stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end
      // Change the stall rate now and then, including stretches with none
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 15;
          default: stall_pct = 40;
        endcase
      end
    end
  end

  // Abort a hung run
  initial begin : watchdog
    #400000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
